// ===== rtl/frb_pkg.sv =====
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants of the frame ring buffer with overwrite of the
// oldest frame.
// ----------------------------------------------------------------------------
package frb_pkg;

    localparam int RING_FRAMES_DEF     = 8;
    localparam int FRAME_MAX_BYTES_DEF = 256;

    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 64;
    localparam int SEQ_W       = 32;
    localparam int CNT_W       = 32;
    localparam int LEN_OUT_W   = 9;
    localparam int DEPTH_OUT_W = 4;

    // Action codes of an input item. The unused code acts as a statistics read.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STATS = 2'd2
    } t_action;

    typedef struct packed {
        logic                   ok;
        logic [BYTE_W-1:0]      read_byte;
        logic                   read_last;
        logic [LEN_OUT_W-1:0]   frame_len;
        logic [SEQ_W-1:0]       frame_seq;
        logic [TIME_W-1:0]      frame_time;
        logic [CNT_W-1:0]       pushes_seen;
        logic [DEPTH_OUT_W-1:0] depth_now;
        logic [CNT_W-1:0]       drops_seen;
    } t_result;

endpackage

// ===== rtl/frb_ram.sv =====
// ----------------------------------------------------------------------------
// frb_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module frb_ram #(
    parameter int DEPTH  = 9,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/frb_ctrl.sv =====
// ----------------------------------------------------------------------------
// frb_ctrl
// Control of the frame ring: slot pointers, counters, read and modify of the
// byte and header memories, and the output register.
// ----------------------------------------------------------------------------
module frb_ctrl #(
    parameter int RING_FRAMES     = frb_pkg::RING_FRAMES_DEF,
    parameter int FRAME_MAX_BYTES = frb_pkg::FRAME_MAX_BYTES_DEF,
    parameter int SLOT_W          = $clog2(RING_FRAMES + 1),
    parameter int OFF_W           = $clog2(FRAME_MAX_BYTES + 1),
    parameter int BADDR_W         = $clog2((RING_FRAMES + 1) * FRAME_MAX_BYTES),
    parameter int HDR_W           = frb_pkg::TIME_W + frb_pkg::SEQ_W + OFF_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [frb_pkg::ACTION_W-1:0]  i_action,
    input  logic [frb_pkg::BYTE_W-1:0]    i_push_byte,
    input  logic                          i_frame_end,
    input  logic [frb_pkg::TIME_W-1:0]    i_push_time,
    output logic                          o_bm_we,
    output logic [BADDR_W-1:0]            o_bm_waddr,
    output logic [frb_pkg::BYTE_W-1:0]    o_bm_wdata,
    output logic                          o_bm_re,
    output logic [BADDR_W-1:0]            o_bm_raddr,
    input  logic [frb_pkg::BYTE_W-1:0]    i_bm_rdata,
    output logic                          o_hm_we,
    output logic [SLOT_W-1:0]             o_hm_waddr,
    output logic [HDR_W-1:0]              o_hm_wdata,
    output logic                          o_hm_re,
    output logic [SLOT_W-1:0]             o_hm_raddr,
    input  logic [HDR_W-1:0]              i_hm_rdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output frb_pkg::t_result              o_res
);

    import frb_pkg::*;

    localparam int SLOT_COUNT = RING_FRAMES + 1;
    localparam int QW         = $clog2(RING_FRAMES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_HOLD  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [QW-1:0]       r_queued, n_queued;
    logic [OFF_W-1:0]    r_fill, n_fill;
    logic [OFF_W-1:0]    r_rd_off, n_rd_off;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [CNT_W-1:0]    r_commits, n_commits;
    logic [CNT_W-1:0]    r_drops, n_drops;
    logic [OFF_W-1:0]    r_fetch_off, n_fetch_off;
    t_result             r_pend, n_pend;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                out_free;
    logic [OFF_W-1:0]    off_cl;
    logic                fill_room;
    logic [OFF_W-1:0]    fill_after;
    logic [SEQ_W-1:0]    seq_inc;
    logic [SEQ_W-1:0]    seq_next;
    logic [OFF_W-1:0]    hm_len;
    logic [SEQ_W-1:0]    hm_seq;
    logic [TIME_W-1:0]   hm_time;
    logic                last;
    t_result             res;
    logic                res_load;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [BADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                     input logic [OFF_W-1:0]  off);
        byte_addr = BADDR_W'(s) * BADDR_W'(FRAME_MAX_BYTES) + BADDR_W'(off);
    endfunction

    assign out_free   = !r_out_valid || i_ready;
    assign off_cl     = (r_rd_off >= OFF_W'(FRAME_MAX_BYTES)) ?
                        OFF_W'(FRAME_MAX_BYTES - 1) : r_rd_off;
    assign fill_room  = r_fill < OFF_W'(FRAME_MAX_BYTES);
    assign fill_after = fill_room ? r_fill + OFF_W'(1) : r_fill;
    assign seq_inc    = r_seq + SEQ_W'(1);
    // Sequence zero is reserved, so the counter skips it on wrap.
    assign seq_next   = (seq_inc == '0) ? SEQ_W'(1) : seq_inc;
    assign hm_len     = i_hm_rdata[OFF_W-1:0];
    assign hm_seq     = i_hm_rdata[OFF_W +: SEQ_W];
    assign hm_time    = i_hm_rdata[OFF_W + SEQ_W +: TIME_W];
    assign last       = ({1'b0, r_fetch_off} + (OFF_W + 1)'(1)) >= {1'b0, hm_len};

    assign o_ready    = (r_state == S_IDLE);

    assign o_bm_waddr = byte_addr(r_wr_slot, r_fill);
    assign o_bm_wdata = i_push_byte;
    assign o_bm_raddr = byte_addr(r_head, off_cl);
    assign o_hm_waddr = r_wr_slot;
    assign o_hm_wdata = {i_push_time, seq_next, fill_after};
    assign o_hm_raddr = r_head;

    always_comb begin
        n_state     = r_state;
        n_wr_slot   = r_wr_slot;
        n_head      = r_head;
        n_queued    = r_queued;
        n_fill      = r_fill;
        n_rd_off    = r_rd_off;
        n_seq       = r_seq;
        n_commits   = r_commits;
        n_drops     = r_drops;
        n_fetch_off = r_fetch_off;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_bm_we     = 1'b0;
        o_bm_re     = 1'b0;
        o_hm_we     = 1'b0;
        o_hm_re     = 1'b0;
        res         = '0;
        res_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            res.ok   = 1'b1;
                            res_load = 1'b1;
                            o_bm_we  = fill_room;
                            n_fill   = fill_after;
                            if (i_frame_end) begin
                                o_hm_we   = 1'b1;
                                n_commits = r_commits + CNT_W'(1);
                                n_seq     = seq_next;
                                n_wr_slot = next_slot(r_wr_slot);
                                n_fill    = '0;
                                if (r_queued >= QW'(RING_FRAMES)) begin
                                    // Full ring: the oldest frame is overwritten.
                                    n_head   = next_slot(r_head);
                                    n_drops  = r_drops + CNT_W'(1);
                                    n_rd_off = '0;
                                end else begin
                                    n_queued = r_queued + QW'(1);
                                end
                            end
                        end
                        ACT_READ: begin
                            if (r_queued == '0) begin
                                res_load = 1'b1;
                            end else begin
                                o_bm_re     = 1'b1;
                                o_hm_re     = 1'b1;
                                n_fetch_off = off_cl;
                                n_state     = S_FETCH;
                            end
                        end
                        default: begin
                            res.ok          = 1'b1;
                            res.pushes_seen = r_commits;
                            res.depth_now   = DEPTH_OUT_W'(r_queued);
                            res.drops_seen  = r_drops;
                            res_load        = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                res.ok         = 1'b1;
                res.read_byte  = i_bm_rdata;
                res.read_last  = last;
                res.frame_len  = LEN_OUT_W'(hm_len);
                res.frame_seq  = hm_seq;
                res.frame_time = hm_time;
                res_load       = 1'b1;
                n_state        = S_IDLE;
                if (last) begin
                    n_head   = next_slot(r_head);
                    n_queued = r_queued - QW'(1);
                    n_rd_off = '0;
                end else begin
                    n_rd_off = r_fetch_off + OFF_W'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A result goes straight to the output register when it is free,
        // otherwise it waits in the pending register.
        if (res_load) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_pend  = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_slot   <= '0;
            r_head      <= '0;
            r_queued    <= '0;
            r_fill      <= '0;
            r_rd_off    <= '0;
            r_seq       <= '0;
            r_commits   <= '0;
            r_drops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_slot   <= n_wr_slot;
            r_head      <= n_head;
            r_queued    <= n_queued;
            r_fill      <= n_fill;
            r_rd_off    <= n_rd_off;
            r_seq       <= n_seq;
            r_commits   <= n_commits;
            r_drops     <= n_drops;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fetch_off <= n_fetch_off;
        r_pend      <= n_pend;
        r_out       <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_queued_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued <= QW'(RING_FRAMES))
        else $error("frame count exceeds the ring size");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= OFF_W'(FRAME_MAX_BYTES))
        else $error("fill offset beyond the frame limit");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bm_re |-> (r_queued != '0))
        else $error("memory read issued on an empty ring");

    a_fetch_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> ($past(r_state) == S_IDLE && $past(o_bm_re)))
        else $error("fetch state without a preceding read");

    a_commit_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hm_we |=> (r_seq != '0))
        else $error("committed frame carries sequence zero");

endmodule

// ===== rtl/frame_ring_buffer_drop_oldest.sv =====
// ----------------------------------------------------------------------------
// frame_ring_buffer_drop_oldest
// Frame FIFO of RING_FRAMES frames that overwrites the oldest frame when full.
// ----------------------------------------------------------------------------
// A push item stores one byte into the spare frame slot and commits the frame
// with its timestamp, length and a nonzero sequence number on its last byte;
// when the ring is full the oldest frame is dropped. A read item returns the
// next byte of the oldest frame with its header, and a statistics item returns
// the counters and the frame count. Push and statistics items are handled in
// the idle state, so one can be accepted each cycle while results are taken.
// A read item waits in the fetch state for the registered memory read, and no
// new item is accepted meanwhile. The memories need no clearing after reset;
// their entries are only read after they have been written.
module frame_ring_buffer_drop_oldest #(
    parameter int RING_FRAMES     = frb_pkg::RING_FRAMES_DEF,
    parameter int FRAME_MAX_BYTES = frb_pkg::FRAME_MAX_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [frb_pkg::ACTION_W-1:0]     i_action,
    input  logic [frb_pkg::BYTE_W-1:0]       i_push_byte,
    input  logic                             i_frame_end,
    input  logic [frb_pkg::TIME_W-1:0]       i_push_time,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_ok,
    output logic [frb_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                             o_read_last,
    output logic [frb_pkg::LEN_OUT_W-1:0]    o_frame_len,
    output logic [frb_pkg::SEQ_W-1:0]        o_frame_seq,
    output logic [frb_pkg::TIME_W-1:0]       o_frame_time,
    output logic [frb_pkg::CNT_W-1:0]        o_pushes_seen,
    output logic [frb_pkg::DEPTH_OUT_W-1:0]  o_depth_now,
    output logic [frb_pkg::CNT_W-1:0]        o_drops_seen
);

    import frb_pkg::*;

    localparam int SLOT_COUNT = RING_FRAMES + 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int OFF_W      = $clog2(FRAME_MAX_BYTES + 1);
    localparam int BDEPTH     = SLOT_COUNT * FRAME_MAX_BYTES;
    localparam int BADDR_W    = $clog2(BDEPTH);
    localparam int HDR_W      = TIME_W + SEQ_W + OFF_W;

    logic               bm_we;
    logic [BADDR_W-1:0] bm_waddr;
    logic [BYTE_W-1:0]  bm_wdata;
    logic               bm_re;
    logic [BADDR_W-1:0] bm_raddr;
    logic [BYTE_W-1:0]  bm_rdata;
    logic               hm_we;
    logic [SLOT_W-1:0]  hm_waddr;
    logic [HDR_W-1:0]   hm_wdata;
    logic               hm_re;
    logic [SLOT_W-1:0]  hm_raddr;
    logic [HDR_W-1:0]   hm_rdata;
    t_result            res;

    frb_ctrl #(
        .RING_FRAMES     (RING_FRAMES),
        .FRAME_MAX_BYTES (FRAME_MAX_BYTES),
        .SLOT_W          (SLOT_W),
        .OFF_W           (OFF_W),
        .BADDR_W         (BADDR_W),
        .HDR_W           (HDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_push_byte (i_push_byte),
        .i_frame_end (i_frame_end),
        .i_push_time (i_push_time),
        .o_bm_we     (bm_we),
        .o_bm_waddr  (bm_waddr),
        .o_bm_wdata  (bm_wdata),
        .o_bm_re     (bm_re),
        .o_bm_raddr  (bm_raddr),
        .i_bm_rdata  (bm_rdata),
        .o_hm_we     (hm_we),
        .o_hm_waddr  (hm_waddr),
        .o_hm_wdata  (hm_wdata),
        .o_hm_re     (hm_re),
        .o_hm_raddr  (hm_raddr),
        .i_hm_rdata  (hm_rdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    // Frame bytes, one row of FRAME_MAX_BYTES per slot.
    frb_ram #(
        .DEPTH  (BDEPTH),
        .DATA_W (BYTE_W),
        .ADDR_W (BADDR_W)
    ) u_byte_mem (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    // Frame headers: timestamp, sequence number and length per slot.
    frb_ram #(
        .DEPTH  (SLOT_COUNT),
        .DATA_W (HDR_W),
        .ADDR_W (SLOT_W)
    ) u_hdr_mem (
        .i_clk   (i_clk),
        .i_we    (hm_we),
        .i_waddr (hm_waddr),
        .i_wdata (hm_wdata),
        .i_re    (hm_re),
        .i_raddr (hm_raddr),
        .o_rdata (hm_rdata)
    );

    assign o_ok          = res.ok;
    assign o_read_byte   = res.read_byte;
    assign o_read_last   = res.read_last;
    assign o_frame_len   = res.frame_len;
    assign o_frame_seq   = res.frame_seq;
    assign o_frame_time  = res.frame_time;
    assign o_pushes_seen = res.pushes_seen;
    assign o_depth_now   = res.depth_now;
    assign o_drops_seen  = res.drops_seen;

endmodule
